// ===== rtl/tle_pkg.sv =====
package tle_pkg;

	localparam int LINE_WIDTH_DEF  = 40;
	localparam int QUEUE_DEPTH_DEF = 2;

	// result kinds
	localparam logic [2:0] KIND_ECHO    = 3'd0;
	localparam logic [2:0] KIND_ERASE   = 3'd1;
	localparam logic [2:0] KIND_NEWLINE = 3'd2;
	localparam logic [2:0] KIND_BELL    = 3'd3;
	localparam logic [2:0] KIND_EOF     = 3'd4;

	localparam int KIND_W  = 3;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 6;
	localparam int STORE_W = 7;

	// register indexes
	localparam logic [1:0] REG_ERASE  = 2'd0;
	localparam logic [1:0] REG_KILL   = 2'd1;
	localparam logic [1:0] REG_WERASE = 2'd2;
	localparam logic [1:0] REG_EOF    = 2'd3;

	localparam logic [7:0] ERASE_RST  = 8'd127;
	localparam logic [7:0] KILL_RST   = 8'd21;
	localparam logic [7:0] WERASE_RST = 8'd23;
	localparam logic [7:0] EOF_RST    = 8'd4;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] LF_CHAR    = 8'h0A;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	typedef struct packed {
		logic printable;
		logic erase;
		logic kill;
		logic werase;
		logic eof;
		logic lf;
	} tle_class_t;

	typedef struct packed {
		logic [7:0] data;
		tle_class_t cls;
	} tle_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT_ERASE,
		ST_EMIT_NL,
		ST_COPY,
		ST_ECHO_B
	} tle_state_t;

endpackage

// ===== rtl/tle_front.sv =====
module tle_front
	import tle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	input  logic [7:0]  in_byte,
	output tle_item_t   item
);

	logic [7:0] erase_q, kill_q, werase_q, eof_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q  <= ERASE_RST;
			kill_q   <= KILL_RST;
			werase_q <= WERASE_RST;
			eof_q    <= EOF_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ERASE:  erase_q  <= pwdata[7:0];
				REG_KILL:   kill_q   <= pwdata[7:0];
				REG_WERASE: werase_q <= pwdata[7:0];
				REG_EOF:    eof_q    <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ERASE:  prdata = {24'd0, erase_q};
			REG_KILL:   prdata = {24'd0, kill_q};
			REG_WERASE: prdata = {24'd0, werase_q};
			REG_EOF:    prdata = {24'd0, eof_q};
			default:    prdata = 32'd0;
		endcase
	end

	// raw match flags; priority against line length is resolved in the back end
	always_comb begin
		item.data          = in_byte;
		item.cls.printable = (in_byte >= PRINT_LO) && (in_byte <= PRINT_HI);
		item.cls.erase     = (in_byte == erase_q);
		item.cls.kill      = (in_byte == kill_q);
		item.cls.werase    = (in_byte == werase_q);
		item.cls.eof       = (in_byte == eof_q);
		item.cls.lf        = (in_byte == LF_CHAR);
	end

endmodule

// ===== rtl/tle_queue.sv =====
module tle_queue
	import tle_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tle_item_t push_item,
	output logic      full,
	output logic      pop_valid,
	output tle_item_t pop_item,
	input  logic      pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tle_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tle_back.sv =====
module tle_back
	import tle_pkg::*;
#(
	parameter int LINE_WIDTH = LINE_WIDTH_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  tle_item_t   q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	localparam int LEN_W = $clog2(LINE_WIDTH + 1);
	localparam int IDX_W = $clog2(LINE_WIDTH);

	tle_state_t         state_q, state_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic               stopped_q, stopped_d;
	logic [LEN_W-1:0]   iss_q, iss_d, tag_q, tag_d, p_q, p_d, k_q, k_d, k_nx;
	logic               chkv_q, chkv_d, want_q, want_d, phase2_q, phase2_d;
	logic               wrap_q, wrap_d;
	logic [7:0]         b_q, b_d;

	logic [STORE_W-1:0] mem [LINE_WIDTH];
	logic [STORE_W-1:0] rdata_q, wr_data;
	logic [IDX_W-1:0]   wr_addr, rd_addr;
	logic               wr_en, rd_en;

	logic               out_valid_q, out_last_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic               can_emit, emit, e_last;
	logic [KIND_W-1:0]  e_kind;
	logic [CHAR_W-1:0]  e_char;
	logic [COUNT_W-1:0] e_cnt;

	logic               hit, done;
	logic [LEN_W-1:0]   res;

	assign can_emit = !out_valid_q || m_tready;
	assign k_nx     = k_q + 1'b1;

	// scanner: one read issued per cycle, checked in the next cycle
	always_comb begin
		hit  = chkv_q && ((rdata_q == SPACE_CHAR[STORE_W-1:0]) == want_q);
		done = 1'b0;
		res  = '0;
		if (hit) begin
			done = 1'b1;
			res  = tag_q;
		end else if (chkv_q ? (tag_q == LEN_W'(1)) : (iss_q == '0)) begin
			done = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		stopped_d = stopped_q;
		iss_d     = iss_q;
		tag_d     = tag_q;
		chkv_d    = chkv_q;
		want_d    = want_q;
		phase2_d  = phase2_q;
		wrap_d    = wrap_q;
		p_d       = p_q;
		k_d       = k_q;
		b_d       = b_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		e_kind    = KIND_ECHO;
		e_char    = '0;
		e_cnt     = '0;
		e_last    = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = len_q[IDX_W-1:0];
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;

		case (state_q)
			ST_IDLE: begin
				if (q_valid && (stopped_q || can_emit)) begin
					q_pop = 1'b1;
					if (stopped_q) begin
						// input has ended: drop the word
					end else if (q_item.cls.printable) begin
						b_d = q_item.data;
						if (len_q < LEN_W'(LINE_WIDTH)) begin
							emit    = 1'b1;
							e_char  = q_item.data;
							e_last  = 1'b1;
							wr_en   = 1'b1;
							wr_data = q_item.data[STORE_W-1:0];
							len_d   = len_q + 1'b1;
						end else if (q_item.data == SPACE_CHAR) begin
							wrap_d  = 1'b0;
							state_d = ST_EMIT_NL;
						end else begin
							wrap_d   = 1'b1;
							iss_d    = len_q;
							chkv_d   = 1'b0;
							want_d   = 1'b1;
							phase2_d = 1'b0;
							state_d  = ST_SCAN;
						end
					end else if (q_item.cls.erase && len_q != '0) begin
						emit   = 1'b1;
						e_kind = KIND_ERASE;
						e_cnt  = COUNT_W'(1);
						e_last = 1'b1;
						len_d  = len_q - 1'b1;
					end else if (q_item.cls.kill) begin
						emit   = 1'b1;
						e_kind = KIND_ERASE;
						e_cnt  = COUNT_W'(len_q);
						e_last = 1'b1;
						len_d  = '0;
					end else if (q_item.cls.werase) begin
						wrap_d   = 1'b0;
						iss_d    = len_q;
						chkv_d   = 1'b0;
						want_d   = 1'b1;
						phase2_d = 1'b0;
						state_d  = ST_SCAN;
					end else if (q_item.cls.eof && len_q == '0) begin
						emit      = 1'b1;
						e_kind    = KIND_EOF;
						e_last    = 1'b1;
						stopped_d = 1'b1;
					end else if (q_item.cls.lf) begin
						emit   = 1'b1;
						e_kind = KIND_NEWLINE;
						e_last = 1'b1;
						len_d  = '0;
					end else begin
						emit   = 1'b1;
						e_kind = KIND_BELL;
						e_last = 1'b1;
					end
				end
			end

			ST_SCAN: begin
				if (iss_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(iss_q - 1'b1);
					tag_d   = iss_q;
					chkv_d  = 1'b1;
					iss_d   = iss_q - 1'b1;
				end
				if (done) begin
					p_d = res;
					if (!wrap_q && !phase2_q) begin
						// word erase: now skip the spaces before the word
						iss_d    = res;
						chkv_d   = 1'b0;
						want_d   = 1'b0;
						phase2_d = 1'b1;
					end else if (wrap_q && res == '0) begin
						state_d = ST_EMIT_NL;
					end else begin
						state_d = ST_EMIT_ERASE;
					end
				end
			end

			ST_EMIT_ERASE: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_kind = KIND_ERASE;
					e_cnt  = COUNT_W'(len_q - p_q);
					if (wrap_q) begin
						state_d = ST_EMIT_NL;
					end else begin
						e_last  = 1'b1;
						len_d   = p_q;
						state_d = ST_IDLE;
					end
				end
			end

			ST_EMIT_NL: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_kind = KIND_NEWLINE;
					len_d  = '0;
					// space in the last column leaves no word to re-echo
					if (wrap_q && p_q != '0 && p_q != LEN_W'(LINE_WIDTH)) begin
						rd_en   = 1'b1;
						rd_addr = p_q[IDX_W-1:0];
						k_d     = p_q;
						state_d = ST_COPY;
					end else begin
						state_d = ST_ECHO_B;
					end
				end
			end

			ST_COPY: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_char  = CHAR_W'(rdata_q);
					wr_en   = 1'b1;
					wr_data = rdata_q;
					len_d   = len_q + 1'b1;
					if (k_q == LEN_W'(LINE_WIDTH - 1)) begin
						state_d = ST_ECHO_B;
					end else begin
						rd_en   = 1'b1;
						rd_addr = k_nx[IDX_W-1:0];
						k_d     = k_nx;
					end
				end
			end

			ST_ECHO_B: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_char  = b_q;
					e_last  = 1'b1;
					wr_en   = 1'b1;
					wr_data = b_q[STORE_W-1:0];
					len_d   = len_q + 1'b1;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			stopped_q   <= 1'b0;
			iss_q       <= '0;
			tag_q       <= '0;
			chkv_q      <= 1'b0;
			want_q      <= 1'b0;
			phase2_q    <= 1'b0;
			wrap_q      <= 1'b0;
			p_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			len_q     <= len_d;
			stopped_q <= stopped_d;
			iss_q     <= iss_d;
			tag_q     <= tag_d;
			chkv_q    <= chkv_d;
			want_q    <= want_d;
			phase2_q  <= phase2_d;
			wrap_q    <= wrap_d;
			p_q       <= p_d;
			k_q       <= k_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		b_q <= b_d;
		if (emit) begin
			out_kind_q <= e_kind;
			out_char_q <= e_char;
			out_cnt_q  <= e_cnt;
			out_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_char_q};
	assign m_tlast  = out_last_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_WIDTH))
		else $error("line length above line width");

	a_copy_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (len_q < k_q))
		else $error("re-echo write overtook read");

	a_erase_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_ERASE) |-> (p_q <= len_q))
		else $error("erase start beyond line end");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("end of input cleared");

	a_no_emit_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q && state_q == ST_IDLE) |-> !emit)
		else $error("result after end of input");

endmodule

// ===== rtl/terminal_line_editor_with_wrap_top.sv =====
// Terminal line editor with word wrap.
// Slave stream (s_*) takes one typed byte per word. Master stream (m_*) gives
// echo actions: tuser is the kind (echo, erase columns, newline, bell, end of
// input), tdata carries the echoed character and erase count, tlast marks the
// final action caused by one typed byte. An ignored byte gives no word.
// The APB port holds the erase, kill, word-erase and eof bytes; write them
// only while the block is idle. pready is tied high.
// Front end: register set and byte classifier feeding a two-entry queue.
// Back end: sequencer owning the line store (registered-read memory), line
// length and the output register.
// A plain byte's word passes the queue and the output register to reach m_*.
// Simple bytes stream through back to back while m_tready stays high. A word
// erase runs two backward scans, one store read per cycle, then the erase.
// A wrap runs a backward scan for the last space, erase, newline, one
// re-echo per cycle while m_tready stays high, then the byte.
// Receiver stall: the output register holds, the sequencer waits, the queue
// fills, then s_tready drops. Reset clears line length, the stopped flag and
// the queue and restores the control bytes (127, 21, 23, 4); the store is not
// cleared.
module terminal_line_editor_with_wrap_top
	import tle_pkg::*;
#(
	parameter int LINE_WIDTH  = LINE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// typed bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// echo actions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_char, [13:8] erase_count, [15:14] zero
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);

	tle_item_t front_item, q_item;
	logic      q_full, q_valid, q_pop;

	assign pready   = 1'b1;
	assign s_tready = !q_full;

	tle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.in_byte (s_tdata),
		.item    (front_item)
	);

	// decouples classification from execution
	tle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_item (front_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop       (q_pop)
	);

	tle_back #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
